### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define DEQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/deq_pkg.sv
// types and constants of the double-ended queue unit
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int INDEX_WIDTH    = 6;

   localparam logic END_HEAD = 1'b0;
   localparam logic END_TAIL = 1'b1;

   typedef enum logic [1:0] {
      OP_PUT,
      OP_GET,
      OP_READ,
      OP_REMOVE
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_MISS,
      STAT_NULL,
      STAT_FULL
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_RM_DONE
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/deq_req_if.sv
// request channel of the double-ended queue unit
`default_nettype none

interface deq_req_if #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
);
   logic                            valid;
   logic                            ready;
   logic [1:0]                      req_type;
   logic                            end_sel;
   logic [DATA_WIDTH-1:0]           value;
   logic [deq_pkg::INDEX_WIDTH-1:0] index;

   modport source (output valid, output req_type, output end_sel, output value,
                   output index, input ready);
   modport sink   (input valid, input req_type, input end_sel, input value,
                   input index, output ready);
endinterface

`default_nettype wire

### hw/rtl/deq_rsp_if.sv
// response channel of the double-ended queue unit
`default_nettype none

interface deq_rsp_if #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
   parameter int DEPTH      = deq_pkg::DEPTH_DEF
);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] result_value;
   logic [1:0]            status;
   logic [CNT_W-1:0]      length;

   modport source (output valid, output result_value, output status, output length,
                   input ready);
   modport sink   (input valid, input result_value, input status, input length,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/double_ended_queue_unit.sv
// double-ended queue of nonzero words kept in a ring buffer memory
//
//   channel   dir  handshake          payload
//   req_ch    in   valid / ready      req_type, end_sel, value, index
//   rsp_ch    out  valid / ready      result_value, status, length
//
// put, get and indexed read: accept with memory read, then execute
// remove: accept with memory read, then search entry by entry, move each entry past
//   the match to close the gap, finish when found; bound by the single memory read port
// reset clears state, head, count and the output valid only; the word memory needs no clearing
// a finished item waits in the output register; a new item is accepted
//   meanwhile, and the step that loads the output register holds until it is free
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
   input wire        clock,
   input wire        reset,
   deq_req_if.sink   req_ch,
   deq_rsp_if.source rsp_ch
);
   import deq_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > INDEX_WIDTH) ? CNT_W : INDEX_WIDTH;

   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                input logic [CNT_W-1:0]  k);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] from_end(input logic             e,
                                                 input logic [CNT_W-1:0] k,
                                                 input logic [CNT_W-1:0] cnt);
      return (e == END_TAIL) ? (cnt - CNT_W'(1) - k) : k;
   endfunction

   logic [DATA_WIDTH-1:0] word_store [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   op_type                op_ff, op_in;
   logic                  end_ff, end_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_length_ff, rsp_length_in;

   logic                  rd_en, wr_en;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rsp_load, out_free;
   logic [ADDR_W-1:0]     head_dec;
   logic [CNT_W:0]        count_x, pos_x, k_x;
   logic                  hit;
   logic [CNT_W-1:0]      first_pos;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign head_dec = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - ADDR_W'(1);
   assign count_x  = {1'b0, count_ff};
   assign pos_x    = {1'b0, pos_ff};
   assign k_x      = {1'b0, k_ff};

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.length       = rsp_length_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      end_in        = end_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STAT_OK;
      rsp_length_in = count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data_ff;
      hit           = 1'b0;
      first_pos     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = op_type'(req_ch.req_type);
               end_in   = req_ch.end_sel;
               value_in = req_ch.value;
               k_in     = '0;
               unique case (op_type'(req_ch.req_type))
                  OP_PUT: begin
                     hit       = 1'b0;
                     first_pos = '0;
                  end
                  OP_GET: begin
                     hit       = (count_ff != '0);
                     first_pos = from_end(req_ch.end_sel, '0, count_ff);
                  end
                  OP_READ: begin
                     hit       = CMP_W'(req_ch.index) < CMP_W'(count_ff);
                     first_pos = from_end(req_ch.end_sel, CNT_W'(req_ch.index), count_ff);
                  end
                  OP_REMOVE: begin
                     hit       = (req_ch.value != '0) && (count_ff != '0);
                     first_pos = from_end(req_ch.end_sel, '0, count_ff);
                  end
               endcase
               pos_in   = first_pos;
               rd_ok_in = hit;
               rd_en    = hit;
               rd_addr  = slot_of(head_ff, first_pos);
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (op_ff)
               OP_PUT: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     if (value_ff == '0) begin
                        rsp_status_in = STAT_NULL;
                     end else if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_data       = value_ff;
                        wr_addr       = (end_ff == END_TAIL) ? slot_of(head_ff, count_ff)
                                                             : head_dec;
                        head_in       = (end_ff == END_TAIL) ? head_ff : head_dec;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_length_in = count_ff + CNT_W'(1);
                     end
                  end
               end
               OP_GET: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     if (!rd_ok_ff) begin
                        rsp_status_in = STAT_MISS;
                     end else begin
                        rsp_value_in  = rd_data_ff;
                        head_in       = (end_ff == END_TAIL) ? head_ff
                                                             : slot_of(head_ff, CNT_W'(1));
                        count_in      = count_ff - CNT_W'(1);
                        rsp_length_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               OP_READ: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     if (!rd_ok_ff) begin
                        rsp_status_in = STAT_MISS;
                     end else begin
                        rsp_value_in = rd_data_ff;
                     end
                  end
               end
               OP_REMOVE: begin
                  priority if (!rd_ok_ff) begin
                     if (out_free) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_MISS;
                        state_in      = S_IDLE;
                     end
                  end else if (rd_data_ff == value_ff) begin
                     if (pos_x + 1'b1 < count_x) begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(head_ff, pos_ff + CNT_W'(1));
                        state_in = S_SHIFT;
                     end else begin
                        state_in = S_RM_DONE;
                     end
                  end else if (k_x + 1'b1 == count_x) begin
                     if (out_free) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_MISS;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     k_in    = k_ff + CNT_W'(1);
                     pos_in  = from_end(end_ff, k_ff + CNT_W'(1), count_ff);
                     rd_en   = 1'b1;
                     rd_addr = slot_of(head_ff, from_end(end_ff, k_ff + CNT_W'(1), count_ff));
                  end
               end
            endcase
         end

         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, pos_ff);
            wr_data = rd_data_ff;
            if (pos_x + 2'd2 < count_x) begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, pos_ff + CNT_W'(2));
               pos_in  = pos_ff + CNT_W'(1);
            end else begin
               state_in = S_RM_DONE;
            end
         end

         S_RM_DONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_value_in  = value_ff;
               count_in      = count_ff - CNT_W'(1);
               rsp_length_in = count_ff - CNT_W'(1);
               state_in      = S_IDLE;
            end
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= word_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      end_ff   <= end_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      k_ff     <= k_in;
      rd_ok_ff <= rd_ok_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= rsp_length_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/deq_checker.sv
// port-level checks of the double-ended queue unit and their binding
`default_nettype none
`include "assert_macros.svh"

module deq_checker #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input wire [DATA_WIDTH-1:0]                 rsp_result_value,
   input wire [1:0]                            rsp_status,
   input wire [$clog2(DEPTH + 1)-1:0]          rsp_length
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // stalled item holds
   `DEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_length), "stalled item changed")

   `DEQ_ASSERT(a_len_bound, clock, reset, !rsp_valid || (rsp_length <= CNT_W'(DEPTH)), "length above depth")

   // failed requests return the null word
   `DEQ_ASSERT(a_fail_null, clock, reset, !rsp_valid || (rsp_status == STAT_OK) || (rsp_result_value == '0), "failed item carries data")

   `DEQ_ASSERT(a_full_len, clock, reset, !rsp_valid || (rsp_status != STAT_FULL) || (rsp_length == CNT_W'(DEPTH)), "full reported below depth")

endmodule

bind double_ended_queue_unit deq_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status),
   .rsp_length       (rsp_ch.length)
);

`default_nettype wire
